>>> sv/mtb_pkg.sv
// shared types and constants for the maglev table builder
`default_nettype none
package mtb_pkg;

	typedef struct packed {
		logic        kind;
		logic [31:0] flow_hash;
	} in_word_t;

	typedef struct packed {
		logic [3:0] backend_index;
		logic [1:0] status;
	} out_word_t;

	localparam logic KIND_BUILD  = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	localparam logic [1:0] ST_LOOKUP    = 2'd0;
	localparam logic [1:0] ST_BUILT     = 2'd1;
	localparam logic [1:0] ST_NOT_BUILT = 2'd2;

	localparam logic [31:0] MUR_C1   = 32'hcc9e2d51;
	localparam logic [31:0] MUR_C2   = 32'h1b873593;
	localparam logic [31:0] MUR_ADD  = 32'he6546b64;
	localparam logic [31:0] MUR_LEN  = 32'd4;
	localparam logic [31:0] MUR_F1   = 32'h85ebca6b;
	localparam logic [31:0] MUR_F2   = 32'hc2b2ae35;

endpackage
`default_nettype wire

>>> sv/mtb_mod.sv
// remainder unit for a constant divisor, by reciprocal multiplication on the shared multiplier
`default_nettype none
module mtb_mod #(
	parameter int DW = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [31:0]   dividend,
	input  wire logic [DW-1:0] divisor,
	input  wire logic [31:0]   recip,
	input  wire logic [63:0]   prod,
	output logic               busy,
	output logic [31:0]        op_a,
	output logic [31:0]        op_b,
	output logic               done,
	output logic [DW-1:0]      rem
);
	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_QUO  = 4'b0010,
		M_SUB  = 4'b0100,
		M_FIX  = 4'b1000
	} mstate_t;

	mstate_t       st_q;
	logic          done_q;
	logic [31:0]   x_q;
	logic [31:0]   rcp_q;
	logic [31:0]   q_q;
	logic [31:0]   r_q;
	logic [DW-1:0] d_q;
	logic [DW-1:0] rem_q;

	// quotient estimate is low by at most one, so one fix-up subtract is enough
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (st_q == M_QUO) begin
			op_a = x_q;
			op_b = rcp_q;
		end else if (st_q == M_SUB) begin
			op_a = q_q;
			op_b = 32'(d_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= M_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				M_IDLE: begin
					if (start) begin
						st_q <= M_QUO;
					end
				end
				M_QUO: begin
					st_q <= M_SUB;
				end
				M_SUB: begin
					st_q <= M_FIX;
				end
				M_FIX: begin
					st_q   <= M_IDLE;
					done_q <= 1'b1;
				end
				default: begin
					st_q <= M_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= dividend;
			d_q   <= divisor;
			rcp_q <= recip;
		end
		if (st_q == M_QUO) begin
			q_q <= prod[63:32];
		end
		if (st_q == M_SUB) begin
			r_q <= x_q - prod[31:0];
		end
		if (st_q == M_FIX) begin
			rem_q <= (r_q >= 32'(d_q)) ? DW'(r_q - 32'(d_q)) : DW'(r_q);
		end
	end

	assign busy = (st_q != M_IDLE);
	assign done = done_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

>>> sv/maglev_table_builder.sv
// lookup: the result word passes the remainder unit, the table read and the result register;
// a new lookup is accepted only once the last result is registered
// build: per backend 4 hash multiplies and two remainders, then a clearing pass over all
// LOOKUP_SIZE table entries, then a read state and a check state per probe of the fill
// input is not ready while an item is in work; one result word may wait
// reset: no table built, lookups answer status 2; num_backends resets to 1
`default_nettype none
module maglev_table_builder #(
	parameter int LOOKUP_SIZE  = 4093,
	parameter int BACKEND_CAP  = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire mtb_pkg::in_word_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output mtb_pkg::out_word_t       out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [4:0]          cfg_data
);
	import mtb_pkg::*;

	localparam int AW  = $clog2(LOOKUP_SIZE);
	localparam int MW  = $clog2(LOOKUP_SIZE + 1);
	localparam int BIW = (BACKEND_CAP > 1) ? $clog2(BACKEND_CAP) : 1;
	localparam int NW  = $clog2(BACKEND_CAP + 1);
	localparam int EW  = BIW + 1;
	localparam int XW  = (BIW > 4) ? BIW : 4;

	// floor(2^32 / divisor) for the two fixed divisors
	localparam logic [31:0] RCP_M  = 32'((64'd1 << 32) / 64'(LOOKUP_SIZE));
	localparam logic [31:0] RCP_M1 = 32'((64'd1 << 32) / 64'(LOOKUP_SIZE - 1));

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_HASH  = 11'b00000000010,
		S_HFIN  = 11'b00000000100,
		S_MODA  = 11'b00000001000,
		S_MODB  = 11'b00000010000,
		S_CLEAR = 11'b00000100000,
		S_FRD   = 11'b00001000000,
		S_FCHK  = 11'b00010000000,
		S_LKMOD = 11'b00100000000,
		S_LKDAT = 11'b01000000000,
		S_PUT   = 11'b10000000000
	} state_t;

	state_t        state_q;
	logic [4:0]    nb_q;
	logic [NW-1:0] n_q;
	logic [BIW-1:0] b_q;
	logic [1:0]    step_q;
	logic [31:0]   acc_q;
	logic [31:0]   h_q;
	logic [AW-1:0] clr_q;
	logic [MW-1:0] filled_q;
	logic          any_q;
	logic          built_q;
	out_word_t     res_q;
	logic          ovalid_q;
	out_word_t     ovalue_q;

	logic [MW-1:0] pos_q  [BACKEND_CAP];
	logic [AW-1:0] cur_q  [BACKEND_CAP];
	logic [AW-1:0] skip_q [BACKEND_CAP];

	logic [EW-1:0] mem [LOOKUP_SIZE];
	logic [EW-1:0] rd_q;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	logic          mod_start;
	logic [31:0]   mod_dividend;
	logic [MW-1:0] mod_divisor;
	logic [31:0]   mod_recip;
	logic          mod_busy;
	logic [31:0]   mod_op_a;
	logic [31:0]   mod_op_b;
	logic          mod_done;
	logic [MW-1:0] mod_rem;

	logic [31:0]   mul_a;
	logic [31:0]   mul_b;
	logic [63:0]   mul_p;
	logic [31:0]   t;
	logic [31:0]   h_fin;
	logic [MW:0]   cur_sum;
	logic [AW-1:0] cur_next;
	logic          last_b;
	logic [NW-1:0] n_clamp;
	logic [XW-1:0] bk_ext;
	logic          in_acc;
	logic          out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = ovalid_q;
	assign out_data  = ovalue_q;
	assign out_free  = !ovalid_q || out_ready;

	// 0 counts as one backend, too many count as the maximum
	always_comb begin
		if (cfg_data == 5'd0 && nb_q == 5'd0) begin
			n_clamp = NW'(1);
		end else if (nb_q == 5'd0) begin
			n_clamp = NW'(1);
		end else if (32'(nb_q) > 32'(BACKEND_CAP)) begin
			n_clamp = NW'(BACKEND_CAP);
		end else begin
			n_clamp = NW'(nb_q);
		end
	end

	// shared multiplier: four hash rounds, or the remainder unit while it runs
	always_comb begin
		t = {acc_q[18:0], acc_q[31:19]};
		t = (t << 2) + t + MUR_ADD;
		t = t ^ MUR_LEN;
		t = t ^ (t >> 16);
		unique case (step_q)
			2'd0: begin
				mul_a = acc_q;
				mul_b = MUR_C1;
			end
			2'd1: begin
				mul_a = {acc_q[16:0], acc_q[31:17]};
				mul_b = MUR_C2;
			end
			2'd2: begin
				mul_a = t;
				mul_b = MUR_F1;
			end
			default: begin
				mul_a = acc_q ^ (acc_q >> 13);
				mul_b = MUR_F2;
			end
		endcase
		if (mod_busy) begin
			mul_a = mod_op_a;
			mul_b = mod_op_b;
		end
		mul_p = mul_a * mul_b;
		h_fin = acc_q ^ (acc_q >> 16);
	end

	assign last_b  = (NW'(b_q) == n_q - NW'(1));
	assign cur_sum = (MW + 1)'(cur_q[b_q]) + (MW + 1)'(skip_q[b_q]);
	assign cur_next = (cur_sum >= (MW + 1)'(LOOKUP_SIZE))
		? AW'(cur_sum - (MW + 1)'(LOOKUP_SIZE)) : AW'(cur_sum);
	assign bk_ext = XW'(rd_q[BIW-1:0]);

	always_comb begin
		mod_start    = 1'b0;
		mod_dividend = in_data.flow_hash;
		mod_divisor  = MW'(LOOKUP_SIZE);
		mod_recip    = RCP_M;
		if (state_q == S_IDLE && in_acc && in_data.kind == KIND_LOOKUP && built_q) begin
			mod_start = 1'b1;
		end else if (state_q == S_HFIN) begin
			mod_start    = 1'b1;
			mod_dividend = h_fin;
		end else if (state_q == S_MODA && mod_done) begin
			mod_start    = 1'b1;
			mod_dividend = h_q;
			mod_divisor  = MW'(LOOKUP_SIZE - 1);
			mod_recip    = RCP_M1;
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_q[b_q];
		wr_en   = 1'b0;
		wr_addr = cur_q[b_q];
		wr_data = {1'b1, b_q};
		if (state_q == S_FRD) begin
			rd_en = (pos_q[b_q] < MW'(LOOKUP_SIZE));
		end else if (state_q == S_LKMOD) begin
			rd_en   = mod_done;
			rd_addr = AW'(mod_rem);
		end else if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (state_q == S_FCHK) begin
			wr_en = !rd_q[EW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	mtb_mod #(.DW(MW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dividend),
		.divisor  (mod_divisor),
		.recip    (mod_recip),
		.prod     (mul_p),
		.busy     (mod_busy),
		.op_a     (mod_op_a),
		.op_b     (mod_op_b),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_HASH) begin
			acc_q <= mul_p[31:0];
		end else if (state_q == S_MODB && mod_done && !last_b) begin
			acc_q <= 32'(b_q + BIW'(1));
		end else if (in_acc) begin
			acc_q <= '0;
		end
		if (state_q == S_HFIN) begin
			h_q <= h_fin;
		end
		if (state_q == S_MODA && mod_done) begin
			cur_q[b_q] <= AW'(mod_rem);
		end
		if (state_q == S_MODB && mod_done) begin
			skip_q[b_q] <= AW'(mod_rem) + AW'(1);
			pos_q[b_q]  <= '0;
		end
		if (state_q == S_FCHK) begin
			pos_q[b_q] <= pos_q[b_q] + MW'(1);
			cur_q[b_q] <= cur_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			nb_q     <= 5'd1;
			n_q      <= NW'(1);
			b_q      <= '0;
			step_q   <= '0;
			clr_q    <= '0;
			filled_q <= '0;
			any_q    <= 1'b0;
			built_q  <= 1'b0;
			res_q    <= '0;
			ovalid_q <= 1'b0;
			ovalue_q <= '0;
		end else begin
			if (cfg_valid) begin
				nb_q <= cfg_data;
			end
			if (ovalid_q && out_ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_data.kind == KIND_BUILD) begin
							n_q     <= n_clamp;
							b_q     <= '0;
							step_q  <= '0;
							state_q <= S_HASH;
						end else if (built_q) begin
							state_q <= S_LKMOD;
						end else begin
							res_q   <= '{backend_index: 4'd0, status: ST_NOT_BUILT};
							state_q <= S_PUT;
						end
					end
				end
				S_HASH: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= S_HFIN;
					end
				end
				S_HFIN: begin
					state_q <= S_MODA;
				end
				S_MODA: begin
					if (mod_done) begin
						state_q <= S_MODB;
					end
				end
				S_MODB: begin
					if (mod_done) begin
						if (last_b) begin
							b_q     <= '0;
							clr_q   <= '0;
							state_q <= S_CLEAR;
						end else begin
							b_q     <= b_q + BIW'(1);
							step_q  <= '0;
							state_q <= S_HASH;
						end
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(LOOKUP_SIZE - 1)) begin
						filled_q <= '0;
						any_q    <= 1'b0;
						state_q  <= S_FRD;
					end
				end
				S_FRD: begin
					if (pos_q[b_q] < MW'(LOOKUP_SIZE)) begin
						state_q <= S_FCHK;
					end else if (!last_b) begin
						b_q <= b_q + BIW'(1);
					end else if (any_q) begin
						b_q   <= '0;
						any_q <= 1'b0;
					end else begin
						built_q <= 1'b1;
						res_q   <= '{backend_index: 4'd0, status: ST_BUILT};
						state_q <= S_PUT;
					end
				end
				S_FCHK: begin
					if (rd_q[EW-1]) begin
						state_q <= S_FRD;
					end else begin
						filled_q <= filled_q + MW'(1);
						// the turn ends on a claim
						if (filled_q + MW'(1) == MW'(LOOKUP_SIZE)) begin
							built_q <= 1'b1;
							res_q   <= '{backend_index: 4'd0, status: ST_BUILT};
							state_q <= S_PUT;
						end else if (!last_b) begin
							b_q     <= b_q + BIW'(1);
							any_q   <= any_q || (pos_q[b_q] + MW'(1) < MW'(LOOKUP_SIZE));
							state_q <= S_FRD;
						end else if (any_q || (pos_q[b_q] + MW'(1) < MW'(LOOKUP_SIZE))) begin
							b_q     <= '0;
							any_q   <= 1'b0;
							state_q <= S_FRD;
						end else begin
							built_q <= 1'b1;
							res_q   <= '{backend_index: 4'd0, status: ST_BUILT};
							state_q <= S_PUT;
						end
					end
				end
				S_LKMOD: begin
					if (mod_done) begin
						state_q <= S_LKDAT;
					end
				end
				S_LKDAT: begin
					res_q.status        <= ST_LOOKUP;
					res_q.backend_index <= rd_q[EW-1] ? bk_ext[3:0] : 4'd0;
					state_q             <= S_PUT;
				end
				S_PUT: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						ovalue_q <= res_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

>>> tb/mtb_checker.sv
// scoreboard for the maglev table builder: watches all channels, predicts and compares
`default_nettype none
module mtb_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire mtb_pkg::in_word_t  in_data,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire mtb_pkg::out_word_t out_data,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic [4:0]         cfg_data,
	output int                      errors,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import mtb_pkg::*;

	localparam int TBL = 4093;
	localparam int NB  = 16;

	logic       slot_used [TBL];
	logic [3:0] slot_owner [TBL];
	logic [31:0] pref_offset [NB];
	logic [31:0] pref_skip [NB];
	int          pref_pos [NB];
	logic [4:0]  backends_reg;
	logic        have_table;
	out_word_t   expected_q [$];

	function automatic logic [31:0] murmur_word(input logic [31:0] w);
		logic [31:0] k;
		logic [31:0] h;
		k = w * MUR_C1;
		k = {k[16:0], k[31:17]};
		k = k * MUR_C2;
		h = {k[18:0], k[31:19]};
		h = h * 32'd5 + MUR_ADD;
		h = h ^ MUR_LEN;
		h = h ^ (h >> 16);
		h = h * MUR_F1;
		h = h ^ (h >> 13);
		h = h * MUR_F2;
		h = h ^ (h >> 16);
		return h;
	endfunction

	function void fill_table();
		int n;
		int filled;
		int s;
		bit live;
		logic [31:0] h;
		logic [63:0] p;
		n = backends_reg;
		if (n < 1) n = 1;
		if (n > NB) n = NB;
		for (int b = 0; b < n; b++) begin
			h = murmur_word(b);
			pref_offset[b] = h % TBL;
			pref_skip[b] = h % (TBL - 1) + 1;
			pref_pos[b] = 0;
		end
		for (int i = 0; i < TBL; i++) begin
			slot_used[i] = 1'b0;
			slot_owner[i] = '0;
		end
		filled = 0;
		forever begin
			for (int b = 0; b < n; b++) begin
				// exhausted backends are passed over without touching a slot
				while (pref_pos[b] < TBL) begin
					p = 64'(pref_offset[b]) + 64'(pref_pos[b]) * 64'(pref_skip[b]);
					s = int'(p % TBL);
					pref_pos[b]++;
					if (!slot_used[s]) begin
						slot_used[s] = 1'b1;
						slot_owner[s] = b[3:0];
						filled++;
						break;
					end
				end
				if (filled >= TBL) return;
			end
			live = 0;
			for (int b = 0; b < n; b++)
				if (pref_pos[b] < TBL) live = 1;
			if (!live) return;
		end
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		out_word_t want;
		if (!arst_n) begin
			errors <= 0;
			backends_reg = 5'd1;
			have_table = 1'b0;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				backends_reg = cfg_data;
			if (in_valid && in_ready) begin
				want.backend_index = '0;
				if (in_data.kind == KIND_BUILD) begin
					fill_table();
					have_table = 1'b1;
					want.status = ST_BUILT;
				end else if (!have_table) begin
					want.status = ST_NOT_BUILT;
				end else begin
					want.status = ST_LOOKUP;
					if (slot_used[in_data.flow_hash % TBL])
						want.backend_index = slot_owner[in_data.flow_hash % TBL];
				end
				expected_q.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result word %p", $realtime, out_data);
					errors <= errors + 1;
				end else begin
					e = expected_q.pop_front();
					if (out_data.backend_index !== e.backend_index) begin
						$display("%0t: backend_index expected %0d actual %0d", $realtime,
							e.backend_index, out_data.backend_index);
						errors <= errors + 1;
					end else if (out_data.status !== e.status) begin
						$display("%0t: status expected %0d actual %0d", $realtime,
							e.status, out_data.status);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> tb/tb_maglev_table_builder.sv
// stimulus, clocking and verdict for the maglev table builder
`default_nettype none
module tb_maglev_table_builder;
	timeunit 1ns;
	timeprecision 1ps;
	import mtb_pkg::*;

	localparam int IDLE_LIMIT = 1000000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [4:0] cfg_data;
	int        errors;
	int        pending;
	int        idle_cycles;
	int        n_lookups;
	int        n_builds;
	int        n_cfgs;

	maglev_table_builder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	mtb_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog on cycles where no word moves on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver stalls, with quiet stretches where it is always ready
	initial begin
		int stall;
		int steady;
		out_ready = 1'b0;
		stall = 0;
		steady = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (steady > 0) begin
				steady--;
				out_ready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 7) == 0) stall = gap_len() + 1;
				else if ($urandom_range(0, 199) == 0) steady = $urandom_range(100, 400);
			end
		end
	end

	task automatic send_word(input logic kind, input logic [31:0] fh);
		int g;
		g = gap_len();
		// valid went low on the last falling edge, so the next word is not driven on that same edge
		repeat (g + 1) @(negedge clk);
		in_valid <= 1'b1;
		in_data.kind <= kind;
		in_data.flow_hash <= fh;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid <= 1'b0;
		if (kind == KIND_BUILD) n_builds++;
		else n_lookups++;
	endtask

	task automatic write_backends(input logic [4:0] v);
		wait (pending == 0);
		repeat (60) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_cfgs++;
	endtask

	function automatic logic [31:0] rand_hash();
		case ($urandom_range(0, 9))
			0: return 32'hffffffff - $urandom_range(0, 8200);
			1: return $urandom_range(0, 8200);
			default: return $urandom();
		endcase
	endfunction

	initial begin
		logic [4:0] v;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_cycles = 0;
		n_lookups = 0;
		n_builds = 0;
		n_cfgs = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// lookups before any build answer not built
		send_word(KIND_LOOKUP, 32'h0);
		send_word(KIND_LOOKUP, 32'hffffffff);
		send_word(KIND_BUILD, 32'hffffffff);
		send_word(KIND_LOOKUP, 32'd0);
		send_word(KIND_LOOKUP, 32'd4092);
		send_word(KIND_LOOKUP, 32'd4093);
		send_word(KIND_LOOKUP, 32'hffffffff);
		write_backends(5'd16);
		// table holds its contents until the next build
		send_word(KIND_LOOKUP, 32'd4092);
		send_word(KIND_BUILD, 32'h0);
		for (int i = 0; i < 6; i++) send_word(KIND_LOOKUP, rand_hash());
		write_backends(5'd0);
		send_word(KIND_BUILD, 32'h0);
		send_word(KIND_LOOKUP, 32'h55555555);
		write_backends(5'd31);
		send_word(KIND_BUILD, 32'h0);
		send_word(KIND_LOOKUP, 32'haaaaaaaa);
		send_word(KIND_LOOKUP, 32'd4094);

		for (int ph = 0; ph < 5; ph++) begin
			case ($urandom_range(0, 3))
				0: v = 5'd1;
				1: v = 5'd17 + 5'($urandom_range(0, 14));
				default: v = 5'($urandom_range(0, 16));
			endcase
			write_backends(v);
			send_word(KIND_BUILD, $urandom());
			for (int i = 0; i < 185; i++) begin
				if ($urandom_range(0, 399) == 0) send_word(KIND_BUILD, $urandom());
				else send_word(KIND_LOOKUP, rand_hash());
			end
		end

		wait (pending == 0);
		repeat (80) @(posedge clk);
		$display("covered %0d lookups and %0d table builds over %0d backend settings",
			n_lookups, n_builds, n_cfgs);
		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
